// File: hw/rtl/cbl_pkg.sv
// Package for the cascaded biquad low-pass filter: widths, section coefficients,
// gain and the controller-to-datapath command type.
// No dependencies; used by cbl_ctrl, cbl_dp and cascaded_biquad_lowpass.
package cbl_pkg;

	localparam int NUM_SECTIONS = 10;
	localparam int COEF_SLOTS   = 16;
	localparam int COEF_IDX_W   = $clog2(COEF_SLOTS);
	localparam int BND_W        = $clog2(NUM_SECTIONS + 1);

	localparam int SAMPLE_W   = 16;
	localparam int VAL_W      = 40;
	localparam int FRAC_W     = 16;
	localparam int COEF_W     = 24;
	localparam int COEF_FRAC  = 22;
	localparam int GAIN_SHIFT = 6;
	localparam int OPND_W     = VAL_W - FRAC_W + 1;
	localparam int PROD_W     = OPND_W + COEF_W;
	localparam int HI_PROD_W  = 2 * COEF_W;
	localparam int FULL_W     = HI_PROD_W + FRAC_W;
	localparam int TERM_W     = FULL_W - COEF_FRAC;
	localparam int ACC_W      = VAL_W + 5;
	localparam int GPROD_W    = SAMPLE_W + COEF_W;

	// four coefficient products, two partial products each
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(7);

	localparam logic [1:0] PROD_B1 = 2'd0;
	localparam logic [1:0] PROD_B0 = 2'd1;
	localparam logic [1:0] PROD_A1 = 2'd2;
	localparam logic [1:0] PROD_A0 = 2'd3;

	function automatic logic signed [COEF_W-1:0] pico_to_q22(input longint unsigned n);
		return COEF_W'((n * 64'd4194304 + 64'd500000000000) / 64'd1000000000000);
	endfunction

	localparam logic signed [COEF_W-1:0] GAIN_Q22 =
		COEF_W'((64'd4194304000000000000 + 64'd17245682377707) / 64'd34491364755414);

	localparam logic signed [COEF_W-1:0] COEF_A0 [COEF_SLOTS] = '{
		pico_to_q22(64'd930359192875), pico_to_q22(64'd804736183667),
		pico_to_q22(64'd694790084692), pico_to_q22(64'd598473745843),
		pico_to_q22(64'd514739344298), pico_to_q22(64'd443359023829),
		pico_to_q22(64'd384718207436), pico_to_q22(64'd339580496050),
		pico_to_q22(64'd308833329156), pico_to_q22(64'd293240387920),
		'0, '0, '0, '0, '0, '0
	};

	localparam logic signed [COEF_W-1:0] COEF_A1 [COEF_SLOTS] = '{
		pico_to_q22(64'd1038711425535), pico_to_q22(64'd993191913366),
		pico_to_q22(64'd973045171604),  pico_to_q22(64'd972092942619),
		pico_to_q22(64'd984631471882),  pico_to_q22(64'd1005307745263),
		pico_to_q22(64'd1029120831379), pico_to_q22(64'd1051557136264),
		pico_to_q22(64'd1068835156979), pico_to_q22(64'd1078202152348),
		'0, '0, '0, '0, '0, '0
	};

	localparam logic signed [COEF_W-1:0] COEF_B0 [COEF_SLOTS] = '{
		pico_to_q22(64'd1000000000000), pico_to_q22(64'd1000000000000),
		pico_to_q22(64'd1000000000000), pico_to_q22(64'd1000000000000),
		pico_to_q22(64'd1000000000000), pico_to_q22(64'd1000000000000),
		pico_to_q22(64'd1000000000000), pico_to_q22(64'd1000000000000),
		pico_to_q22(64'd1000000000000), pico_to_q22(64'd1000000000000),
		'0, '0, '0, '0, '0, '0
	};

	localparam logic signed [COEF_W-1:0] COEF_B1 [COEF_SLOTS] = '{
		pico_to_q22(64'd1303217911466), pico_to_q22(64'd1331445003936),
		pico_to_q22(64'd1386489638591), pico_to_q22(64'd1465296067924),
		pico_to_q22(64'd1562760742808), pico_to_q22(64'd1671334411305),
		pico_to_q22(64'd1780916939543), pico_to_q22(64'd1879416687626),
		pico_to_q22(64'd1954261975354), pico_to_q22(64'd1994780595121),
		'0, '0, '0, '0, '0, '0
	};

	typedef struct packed {
		logic             load;   // input beat taken this cycle
		logic             issue;  // one partial product enters the multiplier
		logic [BND_W-1:0] sec;
		logic [1:0]       prod;
		logic             half;   // 0: upper operand bits, 1: lower 16 bits
		logic             fin;    // close last section, load output register
	} cbl_cmd_t;

endpackage

// File: hw/rtl/cbl_ctrl.sv
// Sequencer for the biquad cascade: handshakes and the partial-product schedule.
// Depends on cbl_pkg; drives cbl_dp through cbl_cmd_t.
module cbl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                smp_valid,
	output logic                smp_ready,
	output logic                res_valid,
	input  logic                res_ready,
	output cbl_pkg::cbl_cmd_t   cmd
);
	import cbl_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [BND_W-1:0] SEC_LAST = BND_W'(NUM_SECTIONS - 1);

	logic [1:0]        state_q;
	logic [BND_W-1:0]  sec_q;
	logic [STEP_W-1:0] step_q;
	logic              drain_q;
	logic              res_valid_q;
	logic              accept;

	assign smp_ready = (state_q == ST_IDLE);
	assign accept    = smp_valid && smp_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd.load  = accept;
		cmd.issue = (state_q == ST_RUN);
		cmd.sec   = sec_q;
		cmd.prod  = step_q[2:1];
		cmd.half  = step_q[0];
		// a waiting result must be taken before the next one overwrites it
		cmd.fin   = (state_q == ST_FIN) && (!res_valid_q || res_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q   <= '0;
			step_q  <= '0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						sec_q   <= '0;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						if (sec_q == SEC_LAST) begin
							state_q <= ST_DRAIN;
							drain_q <= 1'b0;
						end else begin
							sec_q <= sec_q + BND_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					// hold here while the last term passes the product and join registers into the accumulator
					drain_q <= 1'b1;
					if (drain_q)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (cmd.fin)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/cbl_dp.sv
// Datapath for the biquad cascade: gain multiplier, history registers, shared
// split multiplier, term pipeline, accumulator and output register.
// Depends on cbl_pkg; commanded by cbl_ctrl.
module cbl_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cbl_pkg::cbl_cmd_t                    cmd,
	input  logic signed [cbl_pkg::SAMPLE_W-1:0]  sample_in,
	output logic signed [cbl_pkg::SAMPLE_W-1:0]  sample_out
);
	import cbl_pkg::*;

	localparam int NBND = NUM_SECTIONS + 1;
	localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [FULL_W-1:0] RND = FULL_W'(1) <<< (COEF_FRAC - 1);
	localparam int RW = VAL_W + 1 - FRAC_W;

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] a);
		if (a[ACC_W-1:VAL_W-1] != {(ACC_W-VAL_W+1){a[ACC_W-1]}})
			return a[ACC_W-1] ? SAT_MIN : SAT_MAX;
		return a[VAL_W-1:0];
	endfunction

	// two newest inputs seen at each section boundary
	logic signed [VAL_W-1:0] d1_q [NBND];
	logic signed [VAL_W-1:0] d2_q [NBND];

	logic signed [GPROD_W-1:0] gprod_q;
	logic signed [GPROD_W:0]   gsum;
	logic signed [VAL_W-1:0]   scaled_q;

	logic [BND_W-1:0]          rd_idx;
	logic signed [VAL_W-1:0]   op;
	logic signed [OPND_W-1:0]  opnd;
	logic signed [COEF_W-1:0]  coef;
	logic [COEF_IDX_W-1:0]     ci;
	logic                      use_y, use_d2, neg;

	logic                      v_s1, half_s1, neg_s1, first_s1;
	logic [BND_W-1:0]          sec_s1;
	logic signed [PROD_W-1:0]  mul_s1;
	logic signed [PROD_W-1:0]  ph_q;

	logic                      v_s2, neg_s2, first_s2;
	logic [BND_W-1:0]          sec_s2;
	logic signed [FULL_W-1:0]  full_s2;

	logic signed [ACC_W-1:0]   acc_q;
	logic signed [TERM_W-1:0]  term;
	logic signed [ACC_W-1:0]   term_x, base_x;
	logic signed [VAL_W-1:0]   v_in;

	logic                      wr_en;
	logic [BND_W-1:0]          wr_idx;

	logic signed [VAL_W:0]     tz;
	logic signed [RW-1:0]      r;
	logic signed [SAMPLE_W-1:0] out_q;

	// input gain
	always_ff @(posedge clk) begin
		if (cmd.load)
			gprod_q <= sample_in * GAIN_Q22;
	end

	assign gsum = {gprod_q[GPROD_W-1], gprod_q} + (GPROD_W+1)'(1 << (GAIN_SHIFT - 1));

	always_ff @(posedge clk) begin
		scaled_q <= {{(VAL_W-GPROD_W-1+GAIN_SHIFT){gsum[GPROD_W]}}, gsum[GPROD_W:GAIN_SHIFT]};
	end

	// operand and coefficient for the product being issued
	always_comb begin
		ci = COEF_IDX_W'(cmd.sec);
		unique case (cmd.prod)
			PROD_B1: begin coef = COEF_B1[ci]; use_y = 1'b0; use_d2 = 1'b0; neg = 1'b0; end
			PROD_B0: begin coef = COEF_B0[ci]; use_y = 1'b0; use_d2 = 1'b1; neg = 1'b0; end
			PROD_A1: begin coef = COEF_A1[ci]; use_y = 1'b1; use_d2 = 1'b0; neg = 1'b1; end
			PROD_A0: begin coef = COEF_A0[ci]; use_y = 1'b1; use_d2 = 1'b1; neg = 1'b1; end
		endcase
		rd_idx = use_y ? cmd.sec + BND_W'(1) : cmd.sec;
		op     = use_d2 ? d2_q[rd_idx] : d1_q[rd_idx];
		if (cmd.half)
			opnd = {{(OPND_W-FRAC_W){1'b0}}, op[FRAC_W-1:0]};
		else
			opnd = {op[VAL_W-1], op[VAL_W-1:FRAC_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1 && half_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1   <= opnd * coef;
		half_s1  <= cmd.half;
		neg_s1   <= neg;
		first_s1 <= (cmd.prod == PROD_B1);
		sec_s1   <= cmd.sec;
	end

	// join upper and lower partial products, round offset folded in
	always_ff @(posedge clk) begin
		if (v_s1 && !half_s1)
			ph_q <= mul_s1;
		if (v_s1 && half_s1) begin
			full_s2 <= $signed({ph_q[HI_PROD_W-1:0], {FRAC_W{1'b0}}})
				+ {{(FULL_W-PROD_W){mul_s1[PROD_W-1]}}, mul_s1} + RND;
			neg_s2   <= neg_s1;
			first_s2 <= first_s1;
			sec_s2   <= sec_s1;
		end
	end

	assign term   = full_s2[FULL_W-1:COEF_FRAC];
	assign term_x = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
	// input of the section: scaled sample, or the previous section's result
	assign v_in   = (cmd.fin || sec_s2 != '0) ? sat_val(acc_q) : scaled_q;
	assign base_x = first_s2 ? {{(ACC_W-VAL_W){v_in[VAL_W-1]}}, v_in} : acc_q;

	always_ff @(posedge clk) begin
		if (v_s2)
			acc_q <= neg_s2 ? base_x - term_x : base_x + term_x;
	end

	// a boundary shifts its history once its last reader has been issued
	assign wr_en  = (v_s2 && first_s2) || cmd.fin;
	assign wr_idx = cmd.fin ? BND_W'(NUM_SECTIONS) : sec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NBND; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NBND; i++) begin
				if (wr_en && wr_idx == BND_W'(i)) begin
					d2_q[i] <= d1_q[i];
					d1_q[i] <= v_in;
				end
			end
		end
	end

	// truncate toward zero, then saturate to the sample range
	assign tz = {v_in[VAL_W-1], v_in}
		+ (v_in[VAL_W-1] ? (VAL_W+1)'({FRAC_W{1'b1}}) : '0);
	assign r  = tz[VAL_W:FRAC_W];

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (r[RW-1:SAMPLE_W-1] != {(RW-SAMPLE_W+1){r[RW-1]}})
				out_q <= r[RW-1] ? OUT_MIN : OUT_MAX;
			else
				out_q <= r[SAMPLE_W-1:0];
		end
	end

	assign sample_out = out_q;

endmodule

// File: hw/rtl/cascaded_biquad_lowpass.sv
// Cascaded biquad low-pass: ten second-order sections on one shared multiplier.
// Input beats are taken only when idle: a new sample is not accepted until the last
// has run through all sections and reached the output register, which waits while
// an unread result is held (res_valid high, res_ready low). Throughput is set by the
// single multiplier, which takes two partial products for each of the four products
// of a section. Reset (arst_n low, asynchronous) clears the histories and handshakes.
module cascaded_biquad_lowpass (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 smp_valid,
	output logic                                 smp_ready,
	input  logic signed [cbl_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic signed [cbl_pkg::SAMPLE_W-1:0]  sample_out
);
	import cbl_pkg::*;

	cbl_cmd_t cmd;

	cbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cmd       (cmd)
	);

	cbl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

`ifndef SYNTHESIS
	a_start_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_valid && smp_ready) |=> cmd.issue)
		else $error("no multiply issued after input beat");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!res_valid || res_ready))
		else $error("result register overwritten before its beat");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> res_valid)
		else $error("finished sample not presented");

	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (!smp_ready && !cmd.fin))
		else $error("multiply issued outside the run phase");
`endif

endmodule
